FILE: hdl/wbvh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbvh_pkg
// Shared types, constants and binary32 helpers for the wide BVH slot decoder.
// ----------------------------------------------------------------------------
package wbvh_pkg;

   localparam int SLOTS_PER_NODE = 8;

   localparam logic [31:0] EXP_BIAS         = 32'd127;
   localparam logic [7:0]  LEAF_OFFSET_MASK = 8'h1f;
   localparam logic [31:0] POS_INF_BITS     = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF_BITS     = 32'hFF80_0000;
   localparam logic [31:0] QNAN_BITS        = 32'h7FC0_0000;
   localparam logic [31:0] MIN_SCALE_BITS   = 32'h0040_0000;

   typedef enum logic [1:0] {
      KIND_EMPTY    = 2'd0,
      KIND_INTERNAL = 2'd1,
      KIND_LEAF     = 2'd2
   } kind_type;

   // classification of one slot, handed from the decoder to the top level
   typedef struct packed {
      kind_type    kind;
      logic [31:0] target_index;
      logic [1:0]  primitive_count;
      logic        count_valid;
      logic [3:0]  count_next;
   } slot_info_type;

   // leading zeros of a 27-bit word
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (v[i] && !found) begin
            n     = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // q times 2^(e-127) as binary32, exact or overflowing to infinity
   function automatic logic [31:0] scaled_q(input logic [7:0] e, input logic [7:0] q);
      logic [2:0]  p;
      logic [8:0]  ex;
      logic [7:0]  qs;
      logic [31:0] r;
      p = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (q[i]) p = 3'(i);
      end
      ex = {6'd0, p} + {1'b0, e};
      qs = q << (3'd7 - p);
      if (q == 8'd0) begin
         r = (e == 8'hff) ? QNAN_BITS : 32'd0;
      end else if (e == 8'hff || ex >= 9'd255) begin
         r = POS_INF_BITS;
      end else if (ex == 9'd0) begin
         r = MIN_SCALE_BITS;
      end else begin
         r = {1'b0, ex[7:0], qs[6:0], 16'd0};
      end
      return r;
   endfunction

   // binary32 add, round to nearest even, canonical quiet nan
   function automatic logic [31:0] fp32_add(input logic [31:0] a_in, input logic [31:0] b_in);
      logic [31:0] a;
      logic [31:0] b;
      logic        nan_a;
      logic        nan_b;
      logic        inf_a;
      logic        inf_b;
      logic [7:0]  xa;
      logic [7:0]  xb;
      logic [7:0]  d;
      logic [4:0]  dd;
      logic [26:0] am;
      logic [26:0] bm;
      logic [26:0] bs;
      logic [27:0] mask;
      logic [27:0] sum;
      logic [4:0]  lz;
      logic [7:0]  sh;
      logic [26:0] man;
      logic [8:0]  ex;
      logic [7:0]  ef;
      logic        rnd;
      logic [30:0] mag;
      logic [31:0] res;
      nan_a = (a_in[30:23] == 8'hff) && (a_in[22:0] != 23'd0);
      nan_b = (b_in[30:23] == 8'hff) && (b_in[22:0] != 23'd0);
      inf_a = (a_in[30:23] == 8'hff) && (a_in[22:0] == 23'd0);
      inf_b = (b_in[30:23] == 8'hff) && (b_in[22:0] == 23'd0);
      // larger magnitude first
      if (a_in[30:0] < b_in[30:0]) begin
         a = b_in;
         b = a_in;
      end else begin
         a = a_in;
         b = b_in;
      end
      xa   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      xb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      am   = {(a[30:23] != 8'd0), a[22:0], 3'b000};
      bm   = {(b[30:23] != 8'd0), b[22:0], 3'b000};
      d    = xa - xb;
      dd   = (d > 8'd27) ? 5'd27 : d[4:0];
      bs   = bm >> dd;
      mask = (28'd1 << dd) - 28'd1;
      bs[0] = bs[0] | (|({1'b0, bm} & mask));
      if (a[31] == b[31]) sum = {1'b0, am} + {1'b0, bs};
      else                sum = {1'b0, am} - {1'b0, bs};
      // normalise
      lz = lzc27(sum[26:0]);
      if (sum[27]) begin
         man = {sum[27:2], sum[1] | sum[0]};
         ex  = {1'b0, xa} + 9'd1;
         sh  = 8'd0;
      end else begin
         sh  = ({3'd0, lz} < xa) ? {3'd0, lz} : (xa - 8'd1);
         man = sum[26:0] << sh;
         ex  = {1'b0, xa} - {1'b0, sh};
      end
      ef  = man[26] ? ex[7:0] : 8'd0;
      rnd = man[2] & (man[1] | man[0] | man[3]);
      mag = {ef, man[25:3]} + {30'd0, rnd};
      // special operands and results
      if (nan_a || nan_b || (inf_a && inf_b && (a_in[31] != b_in[31]))) begin
         res = QNAN_BITS;
      end else if (inf_a) begin
         res = a_in;
      end else if (inf_b) begin
         res = b_in;
      end else if (sum == 28'd0) begin
         res = {a[31] & b[31], 31'd0};
      end else if (ex >= 9'd255) begin
         res = {a[31], POS_INF_BITS[30:0]};
      end else begin
         res = {a[31], mag};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/wbvh_bound.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbvh_bound
// One box bound: origin plus q times 2^(e-127) in binary32.
// ----------------------------------------------------------------------------
module wbvh_bound
   import wbvh_pkg::*;
(
   input  wire logic [31:0] origin,
   input  wire logic [7:0]  exponent,
   input  wire logic [7:0]  quant,
   output logic      [31:0] bound
);

   logic [31:0] offset;

   // exact scaled offset, then one rounded add
   always_comb begin
      offset = scaled_q(exponent, quant);
      bound  = fp32_add(origin, offset);
   end

endmodule
`default_nettype wire

FILE: hdl/wbvh_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbvh_classify
// Slot classification, target index, primitive count and next internal count.
// ----------------------------------------------------------------------------
module wbvh_classify
   import wbvh_pkg::*;
#(
   parameter int SLOTS_PER_NODE = wbvh_pkg::SLOTS_PER_NODE
)
(
   input  wire logic [7:0]    internal_mask,
   input  wire logic [31:0]   child_base,
   input  wire logic [31:0]   triangle_base,
   input  wire logic [2:0]    slot,
   input  wire logic [7:0]    meta,
   input  wire logic [3:0]    internal_seen,
   output slot_info_type      info
);

   logic       in_node;
   logic [3:0] prior_count;
   logic [7:0] leaf_offset;

   always_comb begin
      in_node     = (32'(slot) < SLOTS_PER_NODE);
      prior_count = (slot == 3'd0) ? 4'd0 : internal_seen;
      leaf_offset = meta & LEAF_OFFSET_MASK;

      info.kind            = KIND_EMPTY;
      info.target_index    = 32'd0;
      info.primitive_count = 2'd0;
      info.count_valid     = in_node;
      info.count_next      = prior_count;

      // empty slots do not advance the count
      if (in_node && meta != 8'd0) begin
         if (internal_mask[slot]) begin
            info.kind         = KIND_INTERNAL;
            info.target_index = child_base + {28'd0, prior_count};
            info.count_next   = prior_count + 4'd1;
         end else begin
            info.kind            = KIND_LEAF;
            info.target_index    = triangle_base + {24'd0, leaf_offset};
            info.primitive_count = 2'({1'b0, meta[5]} + {1'b0, meta[6]} + {1'b0, meta[7]});
         end
      end
   end

endmodule
`default_nettype wire

FILE: hdl/wide_bvh_child_slot_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wide_bvh_child_slot_decode
// Decodes one child slot of a compressed 8-wide BVH node per item.
// ----------------------------------------------------------------------------
// Usage
// The req_ channel carries one slot per item: node header plus the slot's meta
// byte and quantised bounds; slots of a node arrive in slot order.
// The rsp_ channel returns one item per request: kind in rsp_tuser, target
// index, primitive count and the six binary32 box bounds in rsp_tdata.
// An accepted item lands in the input register, then the decode and six
// binary32 adders feed the result register, which drives rsp_tvalid.
// Throughput is one item per clock while rsp_tready stays high; the limit is
// the single pass through the adders between the two registers.
// A stalled receiver holds the result register; one more item may wait in the
// input register, after which req_tready drops until rsp_tready returns.
// Synchronous reset empties both registers and clears the internal slot count.
// ----------------------------------------------------------------------------
module wide_bvh_child_slot_decode
   import wbvh_pkg::*;
#(
   parameter int SLOTS_PER_NODE = wbvh_pkg::SLOTS_PER_NODE
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // origin_x, origin_y, origin_z, exponents, internal_mask, child_base,
   // triangle_base, slot, meta, quant_min, quant_max, zero fill
   input  wire logic [255:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // target_index, primitive_count, min_x, min_y, min_z, max_x, max_y, max_z,
   // zero fill
   output logic      [231:0] rsp_tdata,
   // kind
   output logic      [1:0]   rsp_tuser
);

   logic          s0_valid_ff;
   logic          s0_valid_in;
   logic [250:0]  s0_data_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [225:0]  out_data_ff;
   logic [1:0]    out_kind_ff;
   logic [3:0]    seen_ff;
   logic [3:0]    seen_in;
   logic          advance;
   slot_info_type info;
   logic [31:0]   origin [3];
   logic [31:0]   lo [3];
   logic [31:0]   hi [3];

   // handshake
   always_comb begin
      advance      = !out_valid_ff || rsp_tready;
      req_tready   = !s0_valid_ff || advance;
      s0_valid_in  = (req_tvalid && req_tready) || (s0_valid_ff && !advance);
      out_valid_in = advance ? s0_valid_ff : out_valid_ff;
      seen_in      = (advance && s0_valid_ff && info.count_valid) ? info.count_next : seen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seen_ff      <= 4'd0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) s0_data_ff <= req_tdata[250:0];
   end

   wbvh_classify #(
      .SLOTS_PER_NODE (SLOTS_PER_NODE)
   ) u_classify (
      .internal_mask (s0_data_ff[127:120]),
      .child_base    (s0_data_ff[159:128]),
      .triangle_base (s0_data_ff[191:160]),
      .slot          (s0_data_ff[194:192]),
      .meta          (s0_data_ff[202:195]),
      .internal_seen (seen_ff),
      .info          (info)
   );

   assign origin[0] = s0_data_ff[31:0];
   assign origin[1] = s0_data_ff[63:32];
   assign origin[2] = s0_data_ff[95:64];

   // one adder per bound
   for (genvar a = 0; a < 3; a++) begin : g_axis
      wbvh_bound u_lo (
         .origin   (origin[a]),
         .exponent (s0_data_ff[96 + 8*a +: 8]),
         .quant    (s0_data_ff[203 + 8*a +: 8]),
         .bound    (lo[a])
      );
      wbvh_bound u_hi (
         .origin   (origin[a]),
         .exponent (s0_data_ff[96 + 8*a +: 8]),
         .quant    (s0_data_ff[227 + 8*a +: 8]),
         .bound    (hi[a])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance && s0_valid_ff) begin
         out_kind_ff <= info.kind;
         if (info.kind == KIND_EMPTY) begin
            out_data_ff <= {NEG_INF_BITS, NEG_INF_BITS, NEG_INF_BITS,
                            POS_INF_BITS, POS_INF_BITS, POS_INF_BITS,
                            info.primitive_count, info.target_index};
         end else begin
            out_data_ff <= {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0],
                            info.primitive_count, info.target_index};
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};
   assign rsp_tuser  = out_kind_ff;

`ifndef SYNTH
   // empty results carry no target and no primitives
   a_empty_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EMPTY |-> rsp_tdata[33:0] == 34'd0)
      else $error("empty slot with target or primitives");

   // internal results carry no primitives
   a_internal_noprim : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_INTERNAL |-> rsp_tdata[33:32] == 2'd0)
      else $error("internal slot with primitives");

   // reset clears the internal count
   a_reset_count : assert property (@(posedge clock)
      $past(reset) |-> seen_ff == 4'd0)
      else $error("internal count not cleared by reset");

   // a held item keeps its payload while the result side stalls
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !advance |=> s0_valid_ff && $stable(s0_data_ff))
      else $error("input register lost a waiting item");
`endif

endmodule
`default_nettype wire
